// ----- src/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and constants of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int VAL_W            = 32;
    localparam int PRI_W            = 16;
    localparam int CMD_W            = 2;
    localparam int STATUS_W         = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_SHIFT,
        OP_ROTATE
    } t_chain_op;

    typedef struct packed {
        t_chain_op               op;
        logic signed [VAL_W-1:0] new_value;
        logic signed [PRI_W-1:0] new_priority;
    } t_chain_ctl;

endpackage

// ----- src/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and trades it with neighbors.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic                    i_clk,
    input  t_chain_ctl              i_ctl,
    input  logic                    i_occupied,
    input  logic                    i_next_occupied,
    input  logic                    i_prev_stays,
    input  logic signed [VAL_W-1:0] i_prev_value,
    input  logic signed [PRI_W-1:0] i_prev_priority,
    input  logic signed [VAL_W-1:0] i_next_value,
    input  logic signed [PRI_W-1:0] i_next_priority,
    input  logic signed [VAL_W-1:0] i_head_value,
    input  logic signed [PRI_W-1:0] i_head_priority,
    output logic signed [VAL_W-1:0] o_value,
    output logic signed [PRI_W-1:0] o_priority,
    output logic                    o_stays
);

    logic signed [VAL_W-1:0] r_value;
    logic signed [PRI_W-1:0] r_priority;
    logic signed [VAL_W-1:0] n_value;
    logic signed [PRI_W-1:0] n_priority;

    // entry ahead of the new one keeps its place
    assign o_stays = i_occupied && (r_priority <= i_ctl.new_priority);

    always_comb begin
        n_value    = r_value;
        n_priority = r_priority;
        case (i_ctl.op)
            OP_INSERT: begin
                if (!o_stays) begin
                    if (i_prev_stays) begin
                        n_value    = i_ctl.new_value;
                        n_priority = i_ctl.new_priority;
                    end else begin
                        n_value    = i_prev_value;
                        n_priority = i_prev_priority;
                    end
                end
            end
            OP_SHIFT: begin
                n_value    = i_next_value;
                n_priority = i_next_priority;
            end
            OP_ROTATE: begin
                if (i_next_occupied) begin
                    n_value    = i_next_value;
                    n_priority = i_next_priority;
                end else if (i_occupied) begin
                    n_value    = i_head_value;
                    n_priority = i_head_priority;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value    <= n_value;
        r_priority <= n_priority;
    end

    assign o_value    = r_value;
    assign o_priority = r_priority;

endmodule

// ----- src/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Command decode, occupancy count, list sequencer and output register.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int OCC_W    = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [CMD_W-1:0]           i_cmd,
    input  logic signed [VAL_W-1:0]    i_item_value,
    input  logic signed [PRI_W-1:0]    i_item_priority,
    input  logic signed [VAL_W-1:0]    i_head_value,
    input  logic signed [PRI_W-1:0]    i_head_priority,
    output t_chain_ctl                 o_ctl,
    output logic [OCC_W-1:0]           o_occupancy,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VAL_W-1:0]    o_out_value,
    output logic signed [PRI_W-1:0]    o_out_priority,
    output logic                       o_last
);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(CAPACITY);
    localparam logic [OCC_W-1:0] OCC_ONE  = OCC_W'(1);

    t_state                  r_state, n_state;
    logic [OCC_W-1:0]        r_occ, n_occ;
    logic [OCC_W-1:0]        r_remain, n_remain;
    logic                    r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic signed [VAL_W-1:0] r_value, n_value;
    logic signed [PRI_W-1:0] r_priority, n_priority;
    logic                    r_last, n_last;
    logic                    out_free;
    logic                    accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_value    <= n_value;
        r_priority <= n_priority;
        r_last     <= n_last;
    end

    always_comb begin
        n_state            = r_state;
        n_occ              = r_occ;
        n_remain           = r_remain;
        n_out_valid        = r_out_valid && !i_out_ready;
        n_status           = r_status;
        n_value            = r_value;
        n_priority         = r_priority;
        n_last             = r_last;
        o_ctl.op           = OP_HOLD;
        o_ctl.new_value    = i_item_value;
        o_ctl.new_priority = i_item_priority;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_INSERT: begin
                            n_out_valid = 1'b1;
                            n_value     = '0;
                            n_priority  = '0;
                            n_last      = 1'b1;
                            if (r_occ == OCC_FULL) begin
                                n_status = STATUS_FULL;
                            end else begin
                                n_status = STATUS_OK;
                                n_occ    = r_occ + OCC_ONE;
                                o_ctl.op = OP_INSERT;
                            end
                        end
                        CMD_DELETE: begin
                            n_out_valid = 1'b1;
                            n_last      = 1'b1;
                            if (r_occ == '0) begin
                                n_status   = STATUS_EMPTY;
                                n_value    = '0;
                                n_priority = '0;
                            end else begin
                                n_status   = STATUS_OK;
                                n_value    = i_head_value;
                                n_priority = i_head_priority;
                                n_occ      = r_occ - OCC_ONE;
                                o_ctl.op   = OP_SHIFT;
                            end
                        end
                        CMD_LIST: begin
                            if (r_occ == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STATUS_EMPTY;
                                n_value     = '0;
                                n_priority  = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_state  = S_LIST;
                                n_remain = r_occ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LIST: begin
                // head leaves, chain rotates so it returns after a full pass
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = STATUS_OK;
                    n_value     = i_head_value;
                    n_priority  = i_head_priority;
                    n_last      = (r_remain == OCC_ONE);
                    n_remain    = r_remain - OCC_ONE;
                    o_ctl.op    = OP_ROTATE;
                    if (r_remain == OCC_ONE) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_occupancy    = r_occ;
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_out_value    = r_value;
    assign o_out_priority = r_priority;
    assign o_last         = r_last;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_FULL)
        else $error("occupancy above capacity");

    a_list_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_remain != '0 && r_remain <= r_occ))
        else $error("list counter out of range");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd == CMD_INSERT && r_occ != OCC_FULL)
        |=> (r_occ == $past(r_occ) + OCC_ONE))
        else $error("insert did not grow occupancy");

    a_list_keeps_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> $stable(r_occ))
        else $error("occupancy changed during list");

endmodule

// ----- src/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of up to CAPACITY value/priority entries kept sorted in a
// chain of cells; insert, delete-front and list commands.
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready) carries one command word:
//   insert, delete front entry, or list all entries; unused code 3 is
//   taken and answers nothing
//   output channel (o_out_valid / i_out_ready) carries result words with
//   status, value, priority and a last flag on the final word of a command
// latency and throughput
//   insert and delete: every cell compares and moves in parallel, so the
//   result word appears the cycle after acceptance; one command per cycle
//   while the receiver keeps up; list of n entries: one word per cycle while
//   the receiver keeps up, from the head of the chain while the chain rotates
//   once round; no command is taken meanwhile
// reset
//   synchronous active-low reset empties the queue and drops any pending word;
//   cell contents are not cleared, only the occupancy count
// back-pressure
//   a single output register holds the pending word; while the receiver
//   stalls, the next command or list word waits and the chain holds still
// ----------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [CMD_W-1:0]        i_cmd,
    input  logic signed [VAL_W-1:0] i_item_value,
    input  logic signed [PRI_W-1:0] i_item_priority,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATUS_W-1:0]     o_status,
    output logic signed [VAL_W-1:0] o_out_value,
    output logic signed [PRI_W-1:0] o_out_priority,
    output logic                    o_last
);

    localparam int OCC_W = $clog2(CAPACITY + 1);

    t_chain_ctl              chain_ctl;
    logic [OCC_W-1:0]        occupancy;
    logic                    occupied [CAPACITY];
    logic                    stays    [CAPACITY];
    logic signed [VAL_W-1:0] cell_value    [CAPACITY];
    logic signed [PRI_W-1:0] cell_priority [CAPACITY];

    spq_ctrl #(
        .CAPACITY (CAPACITY),
        .OCC_W    (OCC_W)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_head_value    (cell_value[0]),
        .i_head_priority (cell_priority[0]),
        .o_ctl           (chain_ctl),
        .o_occupancy     (occupancy),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_last          (o_last)
    );

    // the chain: cell 0 is the front of the queue
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                    prev_stays;
        logic                    next_occupied;
        logic signed [VAL_W-1:0] prev_value;
        logic signed [PRI_W-1:0] prev_priority;
        logic signed [VAL_W-1:0] next_value;
        logic signed [PRI_W-1:0] next_priority;

        // cells below the count hold live entries
        assign occupied[gi] = (occupancy > OCC_W'(gi));

        if (gi == 0) begin : g_front
            // front cell takes the new entry when nothing stays ahead of it
            assign prev_stays    = 1'b1;
            assign prev_value    = chain_ctl.new_value;
            assign prev_priority = chain_ctl.new_priority;
        end else begin : g_mid
            assign prev_stays    = stays[gi-1];
            assign prev_value    = cell_value[gi-1];
            assign prev_priority = cell_priority[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_back
            assign next_occupied = 1'b0;
            assign next_value    = cell_value[gi];
            assign next_priority = cell_priority[gi];
        end else begin : g_inner
            assign next_occupied = occupied[gi+1];
            assign next_value    = cell_value[gi+1];
            assign next_priority = cell_priority[gi+1];
        end

        spq_cell u_cell (
            .i_clk           (i_clk),
            .i_ctl           (chain_ctl),
            .i_occupied      (occupied[gi]),
            .i_next_occupied (next_occupied),
            .i_prev_stays    (prev_stays),
            .i_prev_value    (prev_value),
            .i_prev_priority (prev_priority),
            .i_next_value    (next_value),
            .i_next_priority (next_priority),
            .i_head_value    (cell_value[0]),
            .i_head_priority (cell_priority[0]),
            .o_value         (cell_value[gi]),
            .o_priority      (cell_priority[gi]),
            .o_stays         (stays[gi])
        );
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the sorted priority queue against a behavioral copy of the queue
// kept here. Directed commands cover the empty, full and tie cases and the
// field extremes. Random command bursts follow, leaning toward insert or
// delete to sweep the occupancy. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH    = DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS   = 130;
    // no idling on either side once this few commands remain
    localparam int TAIL_ITEMS     = 30;
    // cycles allowed after the last expected word (a full list plus margin)
    localparam int TAIL_CYCLES    = 2 * QUEUE_DEPTH + 8;
    // cycles in a row with no handshake on either channel before giving up
    localparam int WATCHDOG_LIMIT = 2000;

    // the one command code the block takes but never answers
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one command word waiting to be sent
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
        // hold this word back until every expected result word has come
        logic                    drain;
    } t_cmd_word;

    // one result word as the block should return it
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] value;
        logic signed [PRI_W-1:0] prio;
        logic                    last;
    } t_result_word;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    i_in_valid      = 1'b0;
    logic                    o_in_ready;
    logic [CMD_W-1:0]        i_cmd           = CMD_INSERT;
    logic signed [VAL_W-1:0] i_item_value    = '0;
    logic signed [PRI_W-1:0] i_item_priority = '0;
    logic                    o_out_valid;
    logic                    i_out_ready     = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic signed [VAL_W-1:0] o_out_value;
    logic signed [PRI_W-1:0] o_out_priority;
    logic                    o_last;

    // command words not yet sent, and result words not yet returned
    t_cmd_word    pending_cmds[$];
    t_result_word expected_words[$];

    // copy of the queue contents, front entry at index 0
    logic signed [VAL_W-1:0] mdl_values[QUEUE_DEPTH];
    logic signed [PRI_W-1:0] mdl_prios[QUEUE_DEPTH];
    int                      mdl_count = 0;

    logic in_accepted = 1'b0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    int   quiet_count = 0;
    int   errors      = 0;

    sorted_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_value     (o_out_value),
        .o_out_priority  (o_out_priority),
        .o_last          (o_last)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    function automatic t_result_word result_word(input logic [STATUS_W-1:0] status,
                                                 input logic signed [VAL_W-1:0] value,
                                                 input logic signed [PRI_W-1:0] prio,
                                                 input logic last);
        t_result_word w;
        w.status = status;
        w.value  = value;
        w.prio   = prio;
        w.last   = last;
        return w;
    endfunction

    function automatic t_cmd_word cmd_word(input logic [CMD_W-1:0] cmd,
                                           input logic signed [VAL_W-1:0] value,
                                           input logic signed [PRI_W-1:0] prio,
                                           input logic drain);
        t_cmd_word c;
        c.cmd   = cmd;
        c.value = value;
        c.prio  = prio;
        c.drain = drain;
        return c;
    endfunction

    // priorities crowd onto a few values so that ties are common
    function automatic logic signed [PRI_W-1:0] random_prio();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5) begin
            return PRI_W'($signed($urandom_range(0, 4)) - 2);
        end else if (roll < 7) begin
            return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        end
        return PRI_W'($urandom);
    endfunction

    // apply one accepted command to the queue copy and queue up its answer
    task automatic predict_queue_words(input logic [CMD_W-1:0] cmd,
                                       input logic signed [VAL_W-1:0] value,
                                       input logic signed [PRI_W-1:0] prio);
        int pos;
        int idx;
        case (cmd)
            CMD_INSERT: begin
                if (mdl_count >= QUEUE_DEPTH) begin
                    // full: entry dropped, contents unchanged
                    expected_words.push_back(result_word(STATUS_FULL, '0, '0, 1'b1));
                end else begin
                    // new entry goes behind every entry of equal or smaller priority
                    pos = 0;
                    while (pos < mdl_count && mdl_prios[pos] <= prio) pos++;
                    for (idx = mdl_count; idx > pos; idx--) begin
                        mdl_values[idx] = mdl_values[idx-1];
                        mdl_prios[idx]  = mdl_prios[idx-1];
                    end
                    mdl_values[pos] = value;
                    mdl_prios[pos]  = prio;
                    mdl_count++;
                    expected_words.push_back(result_word(STATUS_OK, '0, '0, 1'b1));
                end
            end
            CMD_DELETE: begin
                if (mdl_count == 0) begin
                    expected_words.push_back(result_word(STATUS_EMPTY, '0, '0, 1'b1));
                end else begin
                    expected_words.push_back(result_word(STATUS_OK, mdl_values[0],
                                                         mdl_prios[0], 1'b1));
                    for (idx = 1; idx < mdl_count; idx++) begin
                        mdl_values[idx-1] = mdl_values[idx];
                        mdl_prios[idx-1]  = mdl_prios[idx];
                    end
                    mdl_count--;
                end
            end
            CMD_LIST: begin
                if (mdl_count == 0) begin
                    expected_words.push_back(result_word(STATUS_EMPTY, '0, '0, 1'b1));
                end else begin
                    // one word per entry, front to back, last flag on the final one
                    for (idx = 0; idx < mdl_count; idx++) begin
                        expected_words.push_back(result_word(STATUS_OK, mdl_values[idx],
                                                             mdl_prios[idx],
                                                             idx == mdl_count - 1));
                    end
                end
            end
            default: begin
                // unused code: taken, no answer
            end
        endcase
    endtask

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int counted;
        int mode;
        int burst;
        int roll;
        int ins_limit;
        int k;
        logic [CMD_W-1:0] cmd;

        // empty queue: delete and list both report empty, unused code is silent
        pending_cmds.push_back(cmd_word(CMD_DELETE, $urandom, PRI_W'($urandom), 1'b0));
        pending_cmds.push_back(cmd_word(CMD_LIST, $urandom, PRI_W'($urandom), 1'b0));
        pending_cmds.push_back(cmd_word(CMD_UNUSED, 32'sh7FFFFFFF, 16'sh7FFF, 1'b0));
        // field extremes, with a tie on priority zero
        pending_cmds.push_back(cmd_word(CMD_INSERT, 32'sh7FFFFFFF, 16'sh7FFF, 1'b0));
        pending_cmds.push_back(cmd_word(CMD_INSERT, 32'sh80000000, 16'sh8000, 1'b0));
        pending_cmds.push_back(cmd_word(CMD_INSERT, 32'sh00000000, 16'sh0000, 1'b0));
        pending_cmds.push_back(cmd_word(CMD_INSERT, -32'sd1, 16'sh0000, 1'b0));
        pending_cmds.push_back(cmd_word(CMD_INSERT, 32'sh55AA55AA, -16'sd1, 1'b0));
        pending_cmds.push_back(cmd_word(CMD_LIST, -32'sd1, -16'sd1, 1'b0));
        // fill to capacity
        for (k = 0; k < QUEUE_DEPTH - 5; k++) begin
            pending_cmds.push_back(cmd_word(CMD_INSERT, $urandom, random_prio(), 1'b0));
        end
        // insert into a full queue is dropped
        pending_cmds.push_back(cmd_word(CMD_INSERT, $urandom, 16'sh8000, 1'b0));
        // full list, then drain before the deletes
        pending_cmds.push_back(cmd_word(CMD_LIST, $urandom, PRI_W'($urandom), 1'b0));
        pending_cmds.push_back(cmd_word(CMD_DELETE, $urandom, PRI_W'($urandom), 1'b1));
        pending_cmds.push_back(cmd_word(CMD_DELETE, $urandom, PRI_W'($urandom), 1'b0));

        // random bursts that lean toward filling, emptying or neither
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(8, 24);
            ins_limit = (mode == 0) ? 85 : (mode == 1) ? 40 : 60;
            for (k = 0; k < burst; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 3) begin
                    cmd = CMD_UNUSED;
                end else if (roll < 13) begin
                    cmd = CMD_LIST;
                end else if (roll < ins_limit) begin
                    cmd = CMD_INSERT;
                end else begin
                    cmd = CMD_DELETE;
                end
                pending_cmds.push_back(cmd_word(cmd, $urandom, random_prio(),
                                                (counted == 0) ||
                                                ($urandom_range(0, 39) == 0)));
                if (cmd != CMD_UNUSED) counted++;
            end
        end

        // reset held, then released on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // all commands sent, then all answers back, then a quiet tail
        while (pending_cmds.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // command driver: changes on the falling edge
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_cmds
        t_cmd_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_accepted) begin
            // word still on offer, hold it
        end else if (send_gap != 0) begin
            i_in_valid <= 1'b0;
            send_gap   <= send_gap - 1;
        end else if (pending_cmds.size() == 0 ||
                     (pending_cmds[0].drain && expected_words.size() != 0)) begin
            // nothing left, or waiting for the output side to empty
            i_in_valid <= 1'b0;
        end else begin
            nxt = pending_cmds.pop_front();
            i_in_valid      <= 1'b1;
            i_cmd           <= nxt.cmd;
            i_item_value    <= nxt.value;
            i_item_priority <= nxt.prio;
            // idle burst after this word, except near the end
            if (pending_cmds.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------------
    // receiver ready: stalls in bursts, none near the end
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_ready <= 1'b0;
            stall_left  <= stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (pending_cmds.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                stall_left <= $urandom_range(1, 9);
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: samples both handshakes on the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_words
        t_result_word want;
        logic         in_fire;
        logic         out_fire;
        in_fire  = i_rst_n && i_in_valid && o_in_ready;
        out_fire = i_rst_n && o_out_valid && i_out_ready;
        in_accepted <= in_fire;

        // answers first: a word leaving now belongs to an earlier command
        if (out_fire) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word: status %0d value %0d priority %0d last %0d",
                       o_status, o_out_value, o_out_priority, o_last);
                errors++;
            end else begin
                want = expected_words.pop_front();
                check_field("status", longint'(want.status), longint'(o_status));
                check_field("out_value", longint'($signed(want.value)),
                            longint'($signed(o_out_value)));
                check_field("out_priority", longint'($signed(want.prio)),
                            longint'($signed(o_out_priority)));
                check_field("last", longint'(want.last), longint'(o_last));
            end
        end

        if (in_fire) predict_queue_words(i_cmd, i_item_value, i_item_priority);

        // watchdog on cycles with no handshake at all
        if (in_fire || out_fire) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

endmodule
